// File: rtl/lrce_pkg.sv
// Shared constants, state encoding and control structures of the line raster cell emitter.
`default_nettype none

package lrce_pkg;

    localparam int LRCE_COORD_BITS = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } lrce_state_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
    } lrce_cmd_t;

    typedef struct packed {
        logic out_free;
        logic at_end;
    } lrce_status_t;

endpackage

`default_nettype wire

// File: rtl/line_raster_cell_emitter.sv
// Top level of the line raster cell emitter: integer Bresenham rasterization of one segment.
//
// A segment arrives as one beat on the s_ channel and leaves as one beat per marked cell on
// the m_ channel, in drawing order, with m_tlast set on the final cell. Shallow segments run
// from the endpoint with the smaller column, steep ones from the endpoint with the smaller row.
// Each cell carries its column, row and row-major address row * row_width + column, kept to
// 2*COORD_BITS bits. The cfg_ channel writes row_width; it is always ready and should only be
// written while no segment is in flight.
// Sequence: the input beat's edge loads the segment, the setup state sets up the error term and
// the run state then steps the first cell into the output register. After that one cell is
// produced per cycle while the receiver accepts; a segment has N cells, where N is the larger
// coordinate span plus one, at most 2**COORD_BITS. The per-cell loop is one error update and
// one stride multiply.
// s_tready is high only while the block is idle; it rises again as the last cell enters
// the output register, so the next segment is taken while that cell still waits.
// When the receiver stalls, the cell in the output register holds and stepping pauses.
// Reset (aresetn low, synchronous) empties the output, returns to idle and sets
// row_width to 2**COORD_BITS.
`default_nettype none

module line_raster_cell_emitter
    import lrce_pkg::*;
#(
    parameter int COORD_BITS = LRCE_COORD_BITS
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // s_tdata fields from bit 0 up: start_x, start_y, end_x, end_y.
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // m_tdata fields from bit 0 up: cell_x, cell_y, cell_address.
    output logic [((4*COORD_BITS+7)/8)*8-1:0]          m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic                                       m_tlast,
    input  wire logic [COORD_BITS:0]                   cfg_data,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready
);

    lrce_cmd_t    cmd;
    lrce_status_t status;

    assign cfg_ready = 1'b1;

    lrce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lrce_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .in_data  (s_tdata),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/lrce_ctrl.sv
// Controller state machine that sequences segment load, setup and per-cell stepping.
`default_nettype none

module lrce_ctrl
    import lrce_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire lrce_status_t status,
    output lrce_cmd_t         cmd
);

    lrce_state_t state_reg;
    lrce_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.init   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                if (status.out_free) begin
                    cmd.step = 1'b1;
                    if (status.at_end) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_accept_to_setup: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SETUP))
        else $error("accepted segment did not enter setup");

    a_end_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && status.out_free && status.at_end) |=> (state_reg == ST_IDLE))
        else $error("final cell did not return the controller to idle");

    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == ST_IDLE))
        else $error("input ready raised outside idle");

endmodule

`default_nettype wire

// File: rtl/lrce_dp.sv
// Datapath holding the segment, the Bresenham error term, the stride register and the output register.
`default_nettype none

module lrce_dp
    import lrce_pkg::*;
#(
    parameter int COORD_BITS = LRCE_COORD_BITS
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire lrce_cmd_t                                 cmd,
    output lrce_status_t                                   status,
    input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]         in_data,
    input  wire logic                                      cfg_we,
    input  wire logic [COORD_BITS:0]                       cfg_data,
    input  wire logic                                      m_tready,
    output logic                                           m_tvalid,
    output logic [((4*COORD_BITS+7)/8)*8-1:0]              m_tdata,
    output logic                                           m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int EW     = C + 3;
    localparam int AW     = 2 * C;
    localparam int DATA_W = ((4 * C + 7) / 8) * 8;
    localparam logic [C:0] ROW_WIDTH_RESET = (C + 1)'(1) << C;

    logic [C-1:0]          x1_reg, y1_reg, x2_reg, y2_reg;
    logic [C-1:0]          major_reg, minor_reg, major_end_reg;
    logic                  steep_reg, minor_up_reg;
    logic signed [EW-1:0]  e_reg, inc_keep_reg, inc_move_reg;
    logic [C:0]            row_width_reg;
    logic [C-1:0]          out_x_reg, out_y_reg;
    logic [AW-1:0]         out_addr_reg;
    logic                  out_last_reg, out_valid_reg;

    logic [C:0]            dx, dy;
    logic [C-1:0]          adx, ady, amaj, amin;
    logic [C-1:0]          maj_start, min_start, maj_end;
    logic                  steep, same_sign, fwd;
    logic signed [EW-1:0]  keep_w, move_w;
    logic                  take_minor;
    logic [C-1:0]          cell_x, cell_y;
    logic [2*C:0]          prod;
    logic [2*C:0]          addr_sum;

    always_comb begin
        dx  = {1'b0, x2_reg} - {1'b0, x1_reg};
        dy  = {1'b0, y2_reg} - {1'b0, y1_reg};
        adx = dx[C] ? C'(-dx) : dx[C-1:0];
        ady = dy[C] ? C'(-dy) : dy[C-1:0];
        steep     = ady > adx;
        same_sign = (dx[C] && dy[C]) ||
                    (!dx[C] && (dx != '0) && !dy[C] && (dy != '0));
        if (steep) begin
            fwd       = !dy[C];
            amaj      = ady;
            amin      = adx;
            maj_start = fwd ? y1_reg : y2_reg;
            min_start = fwd ? x1_reg : x2_reg;
            maj_end   = fwd ? y2_reg : y1_reg;
        end else begin
            fwd       = !dx[C];
            amaj      = adx;
            amin      = ady;
            maj_start = fwd ? x1_reg : x2_reg;
            min_start = fwd ? y1_reg : y2_reg;
            maj_end   = fwd ? x2_reg : x1_reg;
        end
        keep_w = $signed({2'b00, amin, 1'b0});
        move_w = keep_w - $signed({2'b00, amaj, 1'b0});
    end

    always_comb begin
        if (steep_reg) begin
            take_minor = !e_reg[EW-1] && (e_reg != '0);
            cell_x     = minor_reg;
            cell_y     = major_reg;
        end else begin
            take_minor = !e_reg[EW-1];
            cell_x     = major_reg;
            cell_y     = minor_reg;
        end
        prod     = {{(C + 1){1'b0}}, cell_y} * {{C{1'b0}}, row_width_reg};
        addr_sum = prod + {(C + 1)'(0), cell_x};
    end

    assign status.out_free = !out_valid_reg || m_tready;
    assign status.at_end   = (major_reg == major_end_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_we) begin
            row_width_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x1_reg <= in_data[C-1:0];
            y1_reg <= in_data[2*C-1:C];
            x2_reg <= in_data[3*C-1:2*C];
            y2_reg <= in_data[4*C-1:3*C];
        end
        if (cmd.init) begin
            major_reg     <= maj_start;
            minor_reg     <= min_start;
            major_end_reg <= maj_end;
            steep_reg     <= steep;
            minor_up_reg  <= same_sign;
            e_reg         <= keep_w - $signed({3'b000, amaj});
            inc_keep_reg  <= keep_w;
            inc_move_reg  <= move_w;
        end else if (cmd.step) begin
            major_reg <= major_reg + C'(1);
            if (take_minor) begin
                minor_reg <= minor_up_reg ? minor_reg + C'(1) : minor_reg - C'(1);
                e_reg     <= e_reg + inc_move_reg;
            end else begin
                e_reg     <= e_reg + inc_keep_reg;
            end
        end
        if (cmd.step) begin
            out_x_reg    <= cell_x;
            out_y_reg    <= cell_y;
            out_addr_reg <= addr_sum[AW-1:0];
            out_last_reg <= status.at_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = DATA_W'({out_addr_reg, out_y_reg, out_x_reg});

    a_step_into_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> status.out_free)
        else $error("cell stepped while the output register was still occupied");

    a_step_fills_output: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |=> out_valid_reg)
        else $error("stepped cell did not reach the output register");

    a_major_within_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.step |-> (major_reg <= major_end_reg))
        else $error("major coordinate ran past the segment end");

endmodule

`default_nettype wire
